// ----- rtl/lcvp_pkg.sv -----
// ----------------------------------------------------------------------------
// lcvp_pkg: shared types and constants for the pinned-LRU item tag cache
// Holds field widths, request and status codes, and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcvp_pkg;

   // Field widths fixed by the interface.
   localparam int ITEM_W  = 12;
   localparam int COUNT_W = 13;
   localparam int ENTRY_W = 4;

   // Default number of cache entries.
   localparam int ENTRIES_DEF = 9;

   // Item counts above this value are treated as this value.
   localparam int MAX_ITEMS = 4096;

   // Request actions.
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_PLAN   = 2'd1;
   localparam logic [1:0] ACT_FILL   = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   // View slots.
   localparam logic [1:0] SLOT_LEFT   = 2'd0;
   localparam logic [1:0] SLOT_MIDDLE = 2'd1;
   localparam logic [1:0] SLOT_RIGHT  = 2'd2;
   localparam logic [1:0] SLOT_BAD    = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_MISS   = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new request
      logic div_step;   // one remainder step on the centre index
      logic view_load;  // register the three visible items, open the scan
      logic scan_step;  // examine one cache entry
      logic commit;     // update the cache and drive the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_last;   // current remainder step is the last one
      logic scan_last;  // current scan entry is the last one
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/lcvp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcvp_ctrl: request sequencer for the pinned-LRU item tag cache
// Walks each request through the remainder, view, entry scan and commit
// phases and issues one command per cycle to the datapath while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module lcvp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output lcvp_pkg::cmd_type     cmd,
   input  wire lcvp_pkg::sts_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_VIEW = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_VIEW;
            end
         end
         S_VIEW: begin
            cmd.view_load = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/lcvp_dpath.sv -----
// ----------------------------------------------------------------------------
// lcvp_dpath: datapath of the pinned-LRU item tag cache
// Holds the item count register, the entry tags, valid bits and stamps,
// a bit-serial remainder unit for the centre index, and the entry scanner
// that finds hits, visible items held and the fill victim.
// ----------------------------------------------------------------------------
`default_nettype none

module lcvp_dpath #(
   parameter int ENTRIES = lcvp_pkg::ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lcvp_pkg::cmd_type             cmd,
   output lcvp_pkg::sts_type                  sts,
   input  wire logic                          csr_write_en,
   input  wire logic [lcvp_pkg::COUNT_W-1:0]  csr_write_data,
   input  wire logic [1:0]                    req_action,
   input  wire logic [lcvp_pkg::ITEM_W-1:0]   req_item,
   input  wire logic [1:0]                    req_view_slot,
   input  wire logic [lcvp_pkg::ITEM_W-1:0]   req_centre,
   input  wire logic                          req_fill_ok,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [lcvp_pkg::ENTRY_W-1:0]       rsp_entry,
   output logic [lcvp_pkg::ITEM_W-1:0]        rsp_item_out
);

   localparam int IW = lcvp_pkg::ITEM_W;
   localparam int CW = lcvp_pkg::COUNT_W;
   localparam int EW = $clog2(ENTRIES);
   localparam logic [EW-1:0] LAST_IDX = EW'(ENTRIES - 1);
   localparam logic [3:0] DIV_LAST = 4'(IW - 1);
   localparam logic [CW+3:0] MAX_WIDE = (CW+4)'(lcvp_pkg::MAX_ITEMS);

   // Item count register.
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Captured request.
   logic [1:0]    act_ff;
   logic [IW-1:0] item_ff;
   logic [1:0]    slot_ff;
   logic          ok_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] n_in;

   // Remainder unit; the remainder stays below the count, so it fits an item.
   logic [IW-1:0] dvd_ff;
   logic [IW-1:0] rem_ff;
   logic [CW-1:0] rem_in;
   logic [3:0]    dcnt_ff;
   logic [CW-1:0] trial;

   // Visible items.
   logic [IW-1:0] vleft_ff;
   logic [IW-1:0] vmid_ff;
   logic [IW-1:0] vright_ff;
   logic [IW-1:0] vleft_in;
   logic [IW-1:0] vright_in;
   logic [IW-1:0] cpos;
   logic [CW-1:0] cpos_inc;
   logic [IW-1:0] look_item;

   // Cache storage.
   logic [ENTRIES-1:0] valid_ff;
   logic [IW-1:0]      tag_ff   [ENTRIES];
   logic [31:0]        stamp_ff [ENTRIES];
   logic [31:0]        uc_ff;
   logic [31:0]        uc_in;

   // Scan state.
   logic [EW-1:0] idx_ff;
   logic          cur_valid;
   logic [IW-1:0] cur_tag;
   logic [31:0]   cur_stamp;
   logic          cur_pinned;
   logic          hit_ff;
   logic [EW-1:0] hit_idx_ff;
   logic          held_l_ff;
   logic          held_m_ff;
   logic          held_r_ff;
   logic          inv_ff;
   logic [EW-1:0] inv_idx_ff;
   logic          best_ff;
   logic [EW-1:0] best_idx_ff;
   logic [31:0]   best_st_ff;

   // Commit decisions.
   logic [EW-1:0] vic_idx;
   logic          vic_ok;
   logic          loaded;
   logic [1:0]    st_in;
   logic [EW-1:0] entry_in;
   logic [IW-1:0] iout_in;
   logic [EW-1:0] wr_idx;
   logic          wr_tag;
   logic          wr_stamp;
   logic          set_valid;
   logic          clr_valid;
   logic          clr_all;

   logic [1:0]         status_ff;
   logic [EW-1:0]      entry_ff;
   logic [IW-1:0]      iout_ff;
   logic               strobe_ff;

   // Configuration register write.
   assign count_in = csr_write_en ? csr_write_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Effective item count, capped at the maximum.
   assign n_in = ({4'b0, count_ff} > MAX_WIDE) ? CW'(lcvp_pkg::MAX_ITEMS) : count_ff;

   // Remainder step: shift in one centre bit, subtract the count if it fits.
   assign trial  = {rem_ff, dvd_ff[IW-1]};
   assign rem_in = (trial >= n_ff) ? (trial - n_ff) : trial;

   assign sts.div_last  = (dcnt_ff == DIV_LAST);
   assign sts.scan_last = (idx_ff == LAST_IDX);

   // Neighbors of the reduced centre, wrapped over the item count.
   assign cpos      = rem_ff;
   assign cpos_inc  = {1'b0, cpos} + CW'(1);
   assign vleft_in  = (cpos == '0) ? IW'(n_ff - CW'(1)) : (cpos - IW'(1));
   assign vright_in = (cpos_inc == n_ff) ? '0 : cpos_inc[IW-1:0];

   // Item targeted by a lookup.
   always_comb begin
      case (slot_ff)
         lcvp_pkg::SLOT_LEFT:  look_item = vleft_ff;
         lcvp_pkg::SLOT_RIGHT: look_item = vright_ff;
         default:              look_item = vmid_ff;
      endcase
   end

   // Entry under the scan pointer.
   assign cur_valid  = valid_ff[idx_ff];
   assign cur_tag    = tag_ff[idx_ff];
   assign cur_stamp  = stamp_ff[idx_ff];
   assign cur_pinned = (cur_tag == vleft_ff) || (cur_tag == vmid_ff) ||
                       (cur_tag == vright_ff);

   // Request capture, remainder unit, view registers and scanner.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         item_ff <= req_item;
         slot_ff <= req_view_slot;
         ok_ff   <= req_fill_ok;
         n_ff    <= n_in;
         dvd_ff  <= req_centre;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in[IW-1:0];
         dvd_ff  <= {dvd_ff[IW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + 4'd1;
      end
      if (cmd.view_load) begin
         vleft_ff  <= vleft_in;
         vmid_ff   <= cpos;
         vright_ff <= vright_in;
         idx_ff    <= '0;
         hit_ff    <= 1'b0;
         held_l_ff <= 1'b0;
         held_m_ff <= 1'b0;
         held_r_ff <= 1'b0;
         inv_ff    <= 1'b0;
         best_ff   <= 1'b0;
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + EW'(1);
         // First valid entry holding the lookup item.
         if (!hit_ff && cur_valid && (cur_tag == look_item)) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         // Which visible items are held.
         if (cur_valid && (cur_tag == vleft_ff)) begin
            held_l_ff <= 1'b1;
         end
         if (cur_valid && (cur_tag == vmid_ff)) begin
            held_m_ff <= 1'b1;
         end
         if (cur_valid && (cur_tag == vright_ff)) begin
            held_r_ff <= 1'b1;
         end
         // Victim: first invalid entry, else oldest unpinned entry.
         if (!inv_ff) begin
            if (!cur_valid) begin
               inv_ff     <= 1'b1;
               inv_idx_ff <= idx_ff;
            end else if (!cur_pinned && (!best_ff || (cur_stamp < best_st_ff))) begin
               best_ff     <= 1'b1;
               best_idx_ff <= idx_ff;
               best_st_ff  <= cur_stamp;
            end
         end
      end
   end

   assign vic_idx = inv_ff ? inv_idx_ff : best_idx_ff;
   assign vic_ok  = inv_ff || best_ff;
   assign loaded  = (n_ff != '0);
   assign uc_in   = uc_ff + 32'd1;

   // Response and cache update decision.
   always_comb begin
      st_in     = lcvp_pkg::ST_REJECT;
      entry_in  = '0;
      iout_in   = '0;
      wr_idx    = vic_idx;
      wr_tag    = 1'b0;
      wr_stamp  = 1'b0;
      set_valid = 1'b0;
      clr_valid = 1'b0;
      clr_all   = 1'b0;
      case (act_ff)
         lcvp_pkg::ACT_LOOKUP: begin
            if (loaded && (slot_ff != lcvp_pkg::SLOT_BAD)) begin
               iout_in = look_item;
               if (hit_ff) begin
                  st_in    = lcvp_pkg::ST_DONE;
                  entry_in = hit_idx_ff;
                  wr_idx   = hit_idx_ff;
                  wr_stamp = 1'b1;
               end else begin
                  st_in = lcvp_pkg::ST_MISS;
               end
            end
         end
         lcvp_pkg::ACT_PLAN: begin
            if (loaded) begin
               // Checked in the order middle, right, left.
               st_in = lcvp_pkg::ST_DONE;
               if (!held_m_ff) begin
                  iout_in = vmid_ff;
               end else if (!held_r_ff) begin
                  iout_in = vright_ff;
               end else if (!held_l_ff) begin
                  iout_in = vleft_ff;
               end else begin
                  st_in = lcvp_pkg::ST_MISS;
               end
            end
         end
         lcvp_pkg::ACT_FILL: begin
            if (({1'b0, item_ff} < n_ff) && vic_ok) begin
               entry_in = vic_idx;
               iout_in  = item_ff;
               if (ok_ff) begin
                  st_in     = lcvp_pkg::ST_DONE;
                  wr_tag    = 1'b1;
                  wr_stamp  = 1'b1;
                  set_valid = 1'b1;
               end else begin
                  st_in     = lcvp_pkg::ST_MISS;
                  clr_valid = 1'b1;
               end
            end
         end
         default: begin
            st_in   = lcvp_pkg::ST_DONE;
            clr_all = 1'b1;
         end
      endcase
   end

   // Valid bits, use counter and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         uc_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.commit;
         if (cmd.commit) begin
            if (clr_all) begin
               valid_ff <= '0;
            end
            if (set_valid) begin
               valid_ff[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
               valid_ff[wr_idx] <= 1'b0;
            end
            if (wr_stamp) begin
               uc_ff <= uc_in;
            end
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= st_in;
         entry_ff  <= entry_in;
         iout_ff   <= iout_in;
      end
   end

   // Tag and stamp storage; entries are read only while valid.
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_tag) begin
         tag_ff[wr_idx] <= item_ff;
      end
      if (cmd.commit && wr_stamp) begin
         stamp_ff[wr_idx] <= uc_in;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_entry    = lcvp_pkg::ENTRY_W'(entry_ff);
   assign rsp_item_out = iout_ff;

endmodule

`default_nettype wire

// ----- rtl/lru_cache_visible_pinned_top.sv -----
// ----------------------------------------------------------------------------
// lru_cache_visible_pinned_top: pinned-LRU item tag cache
//
//   Channel   Ports                               Handshake
//   request   req_action .. req_fill_ok           start, accepted when busy low
//   response  rsp_status, rsp_entry, rsp_item_out rsp_strobe, one cycle
//   config    csr_write_data (item count)         csr_write_en
//
// Each request passes through the bit-serial remainder unit reducing the
// centre index, then the step that forms the visible items, then the
// scanner, which examines the entries one at a time, and a commit step.
// The response strobes in the cycle after commit; busy is low in that cycle
// and the next request may start. Synchronous reset invalidates every entry
// and clears the item count. The response cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_cache_visible_pinned_top #(
   parameter int ENTRIES = lcvp_pkg::ENTRIES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_action,
   input  wire logic [lcvp_pkg::ITEM_W-1:0]   req_item,
   input  wire logic [1:0]                    req_view_slot,
   input  wire logic [lcvp_pkg::ITEM_W-1:0]   req_centre,
   input  wire logic                          req_fill_ok,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [lcvp_pkg::ENTRY_W-1:0]       rsp_entry,
   output logic [lcvp_pkg::ITEM_W-1:0]        rsp_item_out,
   input  wire logic                          csr_write_en,
   input  wire logic [lcvp_pkg::COUNT_W-1:0]  csr_write_data
);

   lcvp_pkg::cmd_type cmd;
   lcvp_pkg::sts_type sts;

   // Request sequencer.
   lcvp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Cache storage and scan datapath.
   lcvp_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_action     (req_action),
      .req_item       (req_item),
      .req_view_slot  (req_view_slot),
      .req_centre     (req_centre),
      .req_fill_ok    (req_fill_ok),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_entry      (rsp_entry),
      .rsp_item_out   (rsp_item_out)
   );

endmodule

`default_nettype wire

// ----- rtl/lcvp_checker.sv -----
// ----------------------------------------------------------------------------
// lcvp_checker: port-level checks for the pinned-LRU item tag cache
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lcvp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_strobe,
   input wire logic [1:0]                  rsp_status,
   input wire logic [lcvp_pkg::ENTRY_W-1:0] rsp_entry,
   input wire logic [lcvp_pkg::ITEM_W-1:0] rsp_item_out
);

   // An accepted request makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // Finishing a request always delivers a response.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("request finished without a response");

   // A response never arrives while a request is still at work.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // One response per request: the strobe lasts a single cycle.
   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // A rejected request reports no entry and no item.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == lcvp_pkg::ST_REJECT)) |->
      ((rsp_entry == '0) && (rsp_item_out == '0)))
      else $error("rejected request carries an entry or item");

endmodule

bind lru_cache_visible_pinned_top lcvp_checker u_lcvp_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_entry    (rsp_entry),
   .rsp_item_out (rsp_item_out)
);

`default_nettype wire

// ----- sim/lru_cache_visible_pinned_top_test.sv -----
// ----------------------------------------------------------------------------
// lru_cache_visible_pinned_top_test: pinned-LRU item tag cache testbench
// Drives lookup, plan, fill and clear requests through the start/busy port.
// A scoreboard keeps its own copy of the tag cache and checks each strobed
// response against the oldest expected one. The item count is swept between
// phases of browsing traffic, with the sender idling at several rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lru_cache_visible_pinned_top_test;

   localparam int IW            = lcvp_pkg::ITEM_W;
   localparam int CW            = lcvp_pkg::COUNT_W;
   localparam int EW            = lcvp_pkg::ENTRY_W;
   localparam int CACHE_ENTRIES = lcvp_pkg::ENTRIES_DEF;
   localparam int CLOCK_PERIOD  = 8;
   localparam int LATENCY       = CACHE_ENTRIES + 15;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 10;

   // Visible items are tried in this order when planning a fetch.
   localparam logic [1:0] PLAN_ORDER [3] =
      '{lcvp_pkg::SLOT_MIDDLE, lcvp_pkg::SLOT_RIGHT, lcvp_pkg::SLOT_LEFT};

   // Item counts swept by the random phases, extremes included.
   localparam logic [CW-1:0] PHASE_COUNT [PHASES] =
      '{13'd3, 13'd4096, 13'd1, 13'd9, 13'd8191, 13'd2, 13'd0, 13'd5, 13'd640,
        13'd4097};

   typedef struct packed {
      logic [1:0]    status;
      logic [EW-1:0] entry;
      logic [IW-1:0] item_out;
   } response_type;

   // Mirror of the tag cache that predicts one response per request.
   class cache_scoreboard;
      logic [CW-1:0] item_count;
      logic [IW-1:0] tag   [CACHE_ENTRIES];
      bit            valid [CACHE_ENTRIES];
      logic [31:0]   stamp [CACHE_ENTRIES];
      logic [31:0]   use_count;
      response_type  expected_q [$];
      int            errors;

      function new();
         item_count = '0;
         use_count  = '0;
         errors     = 0;
         foreach (tag[i]) begin
            tag[i]   = '0;
            valid[i] = 1'b0;
            stamp[i] = '0;
         end
      endfunction

      // Counts above the list limit behave as the limit.
      function int unsigned eff_count();
         if (int'(item_count) > lcvp_pkg::MAX_ITEMS) return lcvp_pkg::MAX_ITEMS;
         return int'(item_count);
      endfunction

      // Item shown in view slot s around the centre; n must be nonzero.
      function logic [IW-1:0] view_item(int unsigned centre, int unsigned s,
                                        int unsigned n);
         return IW'((centre % n + s + n - 1) % n);
      endfunction

      function int find_tag(logic [IW-1:0] item);
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (valid[i] && tag[i] == item) return i;
         return -1;
      endfunction

      // First visible item not held; returns 0 when all three are held.
      function bit first_missing(logic [IW-1:0] centre, output logic [IW-1:0] want);
         logic [IW-1:0] v;
         want = '0;
         for (int k = 0; k < 3; k++) begin
            v = view_item(int'(centre), int'(PLAN_ORDER[k]), eff_count());
            if (find_tag(v) < 0) begin
               want = v;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Apply one accepted request to the mirror and queue its response.
      function void note_request(logic [1:0] action, logic [IW-1:0] item,
                                 logic [1:0] slot, logic [IW-1:0] centre,
                                 logic ok);
         response_type  r;
         int unsigned   n;
         int            hit, first_free, oldest, victim;
         bit            pinned;
         logic [IW-1:0] want;
         r.status   = lcvp_pkg::ST_REJECT;
         r.entry    = '0;
         r.item_out = '0;
         n = eff_count();
         case (action)
            lcvp_pkg::ACT_LOOKUP: begin
               if (n != 0 && slot != lcvp_pkg::SLOT_BAD) begin
                  r.item_out = view_item(int'(centre), int'(slot), n);
                  hit = find_tag(r.item_out);
                  if (hit >= 0) begin
                     use_count  = use_count + 32'd1;
                     stamp[hit] = use_count;
                     r.status   = lcvp_pkg::ST_DONE;
                     r.entry    = EW'(hit);
                  end else begin
                     r.status = lcvp_pkg::ST_MISS;
                  end
               end
            end
            lcvp_pkg::ACT_PLAN: begin
               if (n != 0) begin
                  if (first_missing(centre, want)) begin
                     r.status   = lcvp_pkg::ST_DONE;
                     r.item_out = want;
                  end else begin
                     r.status = lcvp_pkg::ST_MISS;
                  end
               end
            end
            lcvp_pkg::ACT_FILL: begin
               if (int'(item) < n) begin
                  // A free entry wins; otherwise the oldest one not in view.
                  first_free = -1;
                  oldest     = -1;
                  for (int i = 0; i < CACHE_ENTRIES; i++) begin
                     if (!valid[i]) begin
                        if (first_free < 0) first_free = i;
                     end else begin
                        pinned = 1'b0;
                        for (int s = 0; s < 3; s++)
                           if (tag[i] == view_item(int'(centre), s, n)) pinned = 1'b1;
                        if (!pinned && (oldest < 0 || stamp[i] < stamp[oldest]))
                           oldest = i;
                     end
                  end
                  victim = (first_free >= 0) ? first_free : oldest;
                  if (victim >= 0) begin
                     r.entry    = EW'(victim);
                     r.item_out = item;
                     if (ok) begin
                        tag[victim]   = item;
                        valid[victim] = 1'b1;
                        use_count     = use_count + 32'd1;
                        stamp[victim] = use_count;
                        r.status      = lcvp_pkg::ST_DONE;
                     end else begin
                        tag[victim]   = '0;
                        valid[victim] = 1'b0;
                        r.status      = lcvp_pkg::ST_MISS;
                     end
                  end
               end
            end
            default: begin
               // Clear keeps the stamps.
               foreach (tag[i]) begin
                  tag[i]   = '0;
                  valid[i] = 1'b0;
               end
               r.status = lcvp_pkg::ST_DONE;
            end
         endcase
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [EW-1:0] entry,
                                   logic [IW-1:0] item_out);
         response_type want;
         if (expected_q.size() == 0) begin
            $error("response strobe with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (entry !== want.entry) begin
            $error("entry: expected %0d, got %0d", want.entry, entry);
            errors++;
         end
         if (item_out !== want.item_out) begin
            $error("item_out: expected %0d, got %0d", want.item_out, item_out);
            errors++;
         end
      endfunction
   endclass

   logic           clock          = 1'b0;
   logic           reset          = 1'b1;
   logic           start          = 1'b0;
   logic           busy;
   logic [1:0]     req_action     = lcvp_pkg::ACT_LOOKUP;
   logic [IW-1:0]  req_item       = '0;
   logic [1:0]     req_view_slot  = lcvp_pkg::SLOT_LEFT;
   logic [IW-1:0]  req_centre     = '0;
   logic           req_fill_ok    = 1'b0;
   logic           rsp_strobe;
   logic [1:0]     rsp_status;
   logic [EW-1:0]  rsp_entry;
   logic [IW-1:0]  rsp_item_out;
   logic           csr_write_en   = 1'b0;
   logic [CW-1:0]  csr_write_data = '0;

   cache_scoreboard sb;
   int unsigned     quiet_cycles = 0;

   lru_cache_visible_pinned_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_item       (req_item),
      .req_view_slot  (req_view_slot),
      .req_centre     (req_centre),
      .req_fill_ok    (req_fill_ok),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_entry      (rsp_entry),
      .rsp_item_out   (rsp_item_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Check every strobed response.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_status, rsp_entry, rsp_item_out);
   end

   // End the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request, after an optional idle gap, and wait until taken.
   task automatic issue(input logic [1:0] action, input logic [IW-1:0] item,
                        input logic [1:0] slot, input logic [IW-1:0] centre,
                        input logic ok, input int unsigned idle_pct);
      int unsigned gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= action;
      req_item      <= item;
      req_view_slot <= slot;
      req_centre    <= centre;
      req_fill_ok   <= ok;
      do @(posedge clock); while (busy);
      sb.note_request(action, item, slot, centre, ok);
   endtask

   // Hold off new requests until every response has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_count(input logic [CW-1:0] value);
      drain();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.item_count = value;
      csr_write_en  <= 1'b0;
   endtask

   // Browsing traffic: mostly plan, fetch and look around a moving centre,
   // mixed with stray lookups, fills, clears and plans.
   task automatic run_phase(input int unsigned budget, input int unsigned idle_pct);
      int unsigned   n, sent, roll;
      logic [IW-1:0] centre, want;
      bit            missing;
      n      = sb.eff_count();
      sent   = 0;
      centre = IW'($urandom);
      while (sent < budget) begin
         // Move the view one step either way or keep it, or jump anywhere.
         roll = $urandom_range(0, 99);
         if (roll < 15 || n == 0) centre = IW'($urandom);
         else centre = sb.view_item(int'(centre), $urandom_range(0, 2), n);

         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            missing = 1'b0;
            if (n != 0) missing = sb.first_missing(centre, want);
            issue(lcvp_pkg::ACT_PLAN, IW'($urandom), 2'($urandom), centre,
                  1'($urandom), idle_pct);
            sent++;
            if (missing) begin
               issue(lcvp_pkg::ACT_FILL, want, 2'($urandom), centre,
                     $urandom_range(0, 9) != 0, idle_pct);
               sent++;
            end
            issue(lcvp_pkg::ACT_LOOKUP, IW'($urandom), 2'($urandom_range(0, 2)), centre,
                  1'($urandom), idle_pct);
            sent++;
         end else if (roll < 72) begin
            issue(lcvp_pkg::ACT_LOOKUP, IW'($urandom), 2'($urandom_range(0, 3)), centre,
                  1'($urandom), idle_pct);
            sent++;
         end else if (roll < 90) begin
            // Stray fill: usually a listed item, sometimes any item number.
            if (n != 0 && $urandom_range(0, 9) != 0) want = IW'($urandom_range(0, n - 1));
            else want = IW'($urandom);
            issue(lcvp_pkg::ACT_FILL, want, 2'($urandom), centre,
                  $urandom_range(0, 3) != 0, idle_pct);
            sent++;
         end else if (roll < 95) begin
            issue(lcvp_pkg::ACT_CLEAR, IW'($urandom), 2'($urandom), centre,
                  1'($urandom), idle_pct);
            sent++;
         end else begin
            issue(lcvp_pkg::ACT_PLAN, IW'($urandom), 2'($urandom), centre,
                  1'($urandom), idle_pct);
            sent++;
         end
         // Now and then let the block run dry before the next request.
         if ($urandom_range(0, 49) == 0) drain();
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nothing loaded: everything but clear is rejected.
      issue(lcvp_pkg::ACT_LOOKUP, 12'd0, lcvp_pkg::SLOT_MIDDLE, 12'd0, 1'b0, 0);
      issue(lcvp_pkg::ACT_PLAN, 12'd0, lcvp_pkg::SLOT_LEFT, 12'd0, 1'b0, 0);
      issue(lcvp_pkg::ACT_FILL, 12'd0, lcvp_pkg::SLOT_LEFT, 12'd0, 1'b1, 0);
      issue(lcvp_pkg::ACT_CLEAR, 12'hFFF, lcvp_pkg::SLOT_BAD, 12'hFFF, 1'b1, 0);

      // Largest count: view wraps around the top of the list.
      set_count(13'h1FFF);
      issue(lcvp_pkg::ACT_PLAN, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_FILL, 12'hFFF, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b1, 0);
      issue(lcvp_pkg::ACT_FILL, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b1, 0);
      issue(lcvp_pkg::ACT_FILL, 12'hFFE, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b1, 0);
      issue(lcvp_pkg::ACT_LOOKUP, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_LOOKUP, 12'd0, lcvp_pkg::SLOT_MIDDLE, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_LOOKUP, 12'd0, lcvp_pkg::SLOT_RIGHT, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_LOOKUP, 12'd0, lcvp_pkg::SLOT_BAD, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_PLAN, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b0, 0);
      // A failed fetch invalidates the chosen entry.
      issue(lcvp_pkg::ACT_FILL, 12'd7, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b0, 0);
      issue(lcvp_pkg::ACT_CLEAR, 12'd0, lcvp_pkg::SLOT_LEFT, 12'd0, 1'b0, 0);

      // One item: all three slots show item 0, so every copy is pinned and
      // the cache eventually has no victim left.
      set_count(13'd1);
      issue(lcvp_pkg::ACT_FILL, 12'd1, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b1, 0);
      repeat (CACHE_ENTRIES + 1)
         issue(lcvp_pkg::ACT_FILL, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b1, 0);
      issue(lcvp_pkg::ACT_PLAN, 12'd0, lcvp_pkg::SLOT_LEFT, 12'hFFF, 1'b0, 0);

      for (int p = 0; p < PHASES; p++) begin
         set_count(PHASE_COUNT[p]);
         case (p % 4)
            0, 2:    run_phase((PHASE_COUNT[p] == 0) ? 30 : 95, 0);
            1:       run_phase((PHASE_COUNT[p] == 0) ? 30 : 95, 53);
            default: run_phase((PHASE_COUNT[p] == 0) ? 30 : 95, 17);
         endcase
      end

      drain();
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/lcvp_pkg.sv
rtl/lcvp_ctrl.sv
rtl/lcvp_dpath.sv
rtl/lru_cache_visible_pinned_top.sv
rtl/lcvp_checker.sv
sim/lru_cache_visible_pinned_top_test.sv
